/* hdl/esd_pkg.sv */
// shared types, constants and helpers for the escape sequence decoder
package esd_pkg;

	// decoded byte buffer size; one slot stays unused
	localparam int BUFFER_BYTES = 256;
	localparam int CNT_W = $clog2(BUFFER_BYTES);
	localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(BUFFER_BYTES - 1);

	// most results one item can cause
	localparam int MAX_RES = 3;

	// source characters with a meaning
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	// decoded control bytes
	localparam logic [7:0] BYTE_CR  = 8'h0d;
	localparam logic [7:0] BYTE_LF  = 8'h0a;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BSLASH = 2'd1,
		MODE_HEX_HI = 2'd2,
		MODE_HEX_LO = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_LONG = 2'd1,
		ERR_ESC  = 2'd2
	} err_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] total_length;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		mode_t            decode_mode;
		logic [3:0]       high_nibble;
		logic [CNT_W-1:0] byte_count;
		logic             line_end_seen;
		err_t             error_code;
	} dec_state_t;

	// results of one item, in order; count is how many are used
	typedef struct packed {
		out_item_t [MAX_RES-1:0] res;
		logic [1:0]              count;
	} bundle_t;

	// {digit ok, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic out_item_t byte_item(input logic [7:0] b);
		out_item_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		return r;
	endfunction

	function automatic logic is_line_end(input logic [7:0] b);
		return (b == BYTE_CR) || (b == BYTE_LF);
	endfunction

endpackage

/* hdl/esd_decode.sv */
// single-pass decode of one item: next state and the results it causes
module esd_decode
	import esd_pkg::*;
(
	input  dec_state_t cur,
	input  in_item_t   item,
	output dec_state_t nxt,
	output bundle_t    bundle
);

	logic [CNT_W-1:0] cnt;
	logic             line;
	logic [1:0]       n;
	logic             fresh;
	logic             esc_emit;
	logic [7:0]       esc_byte;
	logic [4:0]       hx;

	// walk the item through escape state, then the fresh-character check
	always_comb begin
		nxt = cur;
		bundle = '0;
		cnt = cur.byte_count;
		line = cur.line_end_seen;
		n = '0;
		fresh = 1'b0;
		esc_emit = 1'b0;
		esc_byte = '0;
		hx = hex_digit(item.char_byte);

		if (item.operation == OP_CHAR) begin
			if (cur.error_code == ERR_NONE) begin
				case (cur.decode_mode)
					MODE_NORMAL: begin
						fresh = 1'b1;
					end
					MODE_BSLASH: begin
						nxt.decode_mode = MODE_NORMAL;
						esc_emit = 1'b1;
						if (item.char_byte == CH_R) begin
							esc_byte = BYTE_CR;
						end else if (item.char_byte == CH_N) begin
							esc_byte = BYTE_LF;
						end else if (item.char_byte == CH_T) begin
							esc_byte = BYTE_TAB;
						end else if (item.char_byte == CH_BSLASH) begin
							esc_byte = CH_BSLASH;
						end else if (item.char_byte == CH_X) begin
							esc_emit = 1'b0;
							nxt.decode_mode = MODE_HEX_HI;
						end else begin
							// unknown escape: keep the backslash, redo the char
							esc_byte = CH_BSLASH;
							fresh = 1'b1;
						end
					end
					MODE_HEX_HI: begin
						if (!hx[4]) begin
							nxt.error_code = ERR_ESC;
							nxt.decode_mode = MODE_NORMAL;
						end else begin
							nxt.high_nibble = hx[3:0];
							nxt.decode_mode = MODE_HEX_LO;
						end
					end
					MODE_HEX_LO: begin
						nxt.decode_mode = MODE_NORMAL;
						if (!hx[4]) begin
							nxt.error_code = ERR_ESC;
						end else begin
							esc_emit = 1'b1;
							esc_byte = {cur.high_nibble, hx[3:0]};
						end
					end
					default: begin
						nxt.decode_mode = MODE_NORMAL;
					end
				endcase

				// byte finished by an escape; its slot was reserved already
				if (esc_emit) begin
					bundle.res[n] = byte_item(esc_byte);
					n = n + 2'd1;
					cnt = cnt + 1'b1;
					if (is_line_end(esc_byte)) begin
						line = 1'b1;
					end
				end

				// fresh source character with capacity check
				if (fresh) begin
					if (cnt >= CAPACITY) begin
						nxt.error_code = ERR_LONG;
						nxt.decode_mode = MODE_NORMAL;
					end else if (item.char_byte == CH_BSLASH) begin
						nxt.decode_mode = MODE_BSLASH;
					end else begin
						bundle.res[n] = byte_item(item.char_byte);
						n = n + 2'd1;
						cnt = cnt + 1'b1;
						if (is_line_end(item.char_byte)) begin
							line = 1'b1;
						end
					end
				end
			end
			nxt.byte_count = cnt;
			nxt.line_end_seen = line;
		end else begin
			// end of command: flush escapes, cr unless line end or error, report
			if (cur.error_code == ERR_NONE) begin
				if (cur.decode_mode == MODE_BSLASH) begin
					bundle.res[n] = byte_item(CH_BSLASH);
					n = n + 2'd1;
					cnt = cnt + 1'b1;
				end else if (cur.decode_mode == MODE_HEX_HI ||
					cur.decode_mode == MODE_HEX_LO) begin
					nxt.error_code = ERR_ESC;
				end
			end
			if (nxt.error_code == ERR_NONE && !line) begin
				if (cnt >= CAPACITY) begin
					nxt.error_code = ERR_LONG;
				end else begin
					bundle.res[n] = byte_item(BYTE_CR);
					n = n + 2'd1;
					cnt = cnt + 1'b1;
				end
			end
			bundle.res[n].done_res = 1'b1;
			bundle.res[n].status = nxt.error_code;
			bundle.res[n].total_length = 8'(cnt);
			n = n + 2'd1;

			nxt.decode_mode = MODE_NORMAL;
			nxt.high_nibble = '0;
			nxt.byte_count = '0;
			nxt.line_end_seen = 1'b0;
			nxt.error_code = ERR_NONE;
		end
		bundle.count = n;
	end

endmodule

/* hdl/esd_out_queue.sv */
// holds one item's results, handed out one per cycle unless res_stall
module esd_out_queue
	import esd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  bundle_t   bundle,
	output logic      free,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	out_item_t [MAX_RES-1:0] res_s2;
	logic [1:0]              cnt_s2;
	logic                    valid_s2;
	logic [1:0]              idx_q;
	logic                    last;
	logic                    take;

	// current result and whether it closes the item's run
	assign last = (idx_q == (cnt_s2 - 2'd1));
	assign take = valid_s2 && !res_stall;
	assign free = !valid_s2 || (take && last);
	assign res_valid = valid_s2;

	always_comb begin
		res = res_s2[idx_q];
		res.last_of_run = last;
	end

	// control: valid and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
				idx_q <= '0;
			end else if (take) begin
				if (last) begin
					valid_s2 <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= bundle.res;
			cnt_s2 <= bundle.count;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("results loaded over undelivered ones");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < cnt_s2))
		else $error("read index past the item's result count");

	a_idx_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last && !load) |=> (idx_q == $past(idx_q) + 2'd1))
		else $error("read index did not advance after a taken result");

endmodule

/* hdl/escape_sequence_decoder_core.sv */
// Escape sequence decoder: takes one command character or end item per cycle
// while cmd_stall is low; results pass the input and the result register.
// Throughput: one item per cycle, res_stall low, at most one result per item;
// an item's k results (k <= 3) hold the result register until all are taken.
// Reset (arst_n low, asynchronous) empties both stages and clears decode state.
// Items that yield no result retire from the input stage without waiting.
module escape_sequence_decoder_core
	import esd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_item_t  cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic       valid_s1;
	in_item_t   item_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	bundle_t    bundle;
	logic       free;
	logic       adv;
	logic       load;
	logic       accept;

	// input stage retires when its results fit in the result register
	assign adv = valid_s1 && ((bundle.count == 2'd0) || free);
	assign load = adv && (bundle.count != 2'd0);
	assign cmd_stall = valid_s1 && !adv;
	assign accept = cmd_valid && !cmd_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
	end

	// decode state, updated as each item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.decode_mode <= MODE_NORMAL;
			state_q.high_nibble <= '0;
			state_q.byte_count <= '0;
			state_q.line_end_seen <= 1'b0;
			state_q.error_code <= ERR_NONE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	esd_decode u_decode (
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.bundle (bundle)
	);

	esd_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_count <= CAPACITY)
		else $error("byte count beyond capacity");

	a_error_mode_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error_code != ERR_NONE) |-> (state_q.decode_mode == MODE_NORMAL))
		else $error("escape state held while in error");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.operation == OP_END) |=>
		(state_q.byte_count == '0 && state_q.error_code == ERR_NONE))
		else $error("state not cleared after end item");

endmodule
